/* rtl/lru_pkg.sv */
package lru_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  typedef enum logic [1:0] {
    OUTCOME_HIT     = 2'd0,
    OUTCOME_LOAD    = 2'd1,
    OUTCOME_REPLACE = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [15:0] page_number;
    logic        last_request;
  } req_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [2:0]  frame_index;
    logic [15:0] evicted_page;
    logic [31:0] fault_total;
    logic        run_end;
  } rsp_t;

  // register index, taken from paddr[2]
  localparam logic REG_FRAMES_IN_USE = 1'b0;
  localparam logic [3:0] FRAMES_IN_USE_RESET = 4'd8;

endpackage

/* rtl/lru_cfg.sv */
module lru_cfg #(
  parameter int FRAMES = 8,
  parameter int CNT_W  = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [CNT_W-1:0] frames_n
);
  import lru_pkg::*;

  logic [3:0] frames_in_use_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_FRAMES_IN_USE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= FRAMES_IN_USE_RESET;
    end else if (wr_en) begin
      frames_in_use_r <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAMES_IN_USE) begin
      prdata = 32'(frames_in_use_r);
    end
  end

  // zero acts as one frame, anything above the array size as the full array
  always_comb begin
    if (32'(frames_in_use_r) > FRAMES) begin
      frames_n = CNT_W'(FRAMES);
    end else if (frames_in_use_r == 4'd0) begin
      frames_n = CNT_W'(1);
    end else begin
      frames_n = CNT_W'(frames_in_use_r);
    end
  end

endmodule

/* rtl/lru_page_replacement_top.sv */
// channel   direction  handshake                  payload
// request   in         start & !busy              in_data  (lru_pkg::req_t)
// result    out        out_strobe, one cycle      out_data (lru_pkg::rsp_t)
// config    in         psel & penable & pwrite    pwdata, paddr[2] selects register
//
// a request scans the n frames, then writes back, before the next accept, n being the
// effective frame count; the scan reads one frame entry per cycle from the frame
// memory through a single compare unit
// the result shows on out_strobe the cycle after the frame write-back
// reset is synchronous and needs no clearing pass: frames carry valid bits
// the receiver cannot stall; a new request may start while a result shows
module lru_page_replacement_top #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  lru_pkg::req_t in_data,
  output logic          out_strobe,
  output lru_pkg::rsp_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import lru_pkg::*;

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]     frames_n;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     issue_r;
  logic [CNT_W-1:0]     fill_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [PAGE_BITS-1:0] page_q;
  logic [PAGE_BITS-1:0] best_page_r;
  logic [PAGE_BITS-1:0] page_in;
  logic [31:0]          page_ext;
  logic                 last_r;
  logic [31:0]          stamp_q;
  logic [31:0]          best_stamp_r;
  logic [31:0]          clock_r;
  logic [31:0]          fault_r;
  logic [31:0]          fault_nxt;
  logic [FRAMES-1:0]    valid_r;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic [IDX_W-1:0]     hit_idx_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic                 hit_r;
  logic                 out_strobe_r;
  rsp_t                 out_data_r;

  logic                 accept;
  logic                 rd_en;
  logic                 do_write;
  logic                 scan_done;
  logic                 hit_now;
  logic                 older;
  logic                 miss;
  logic                 load;
  logic [IDX_W-1:0]     slot;
  outcome_t             outcome;
  logic [31:0]          evict_ext;
  logic [31:0]          slot_ext;

  logic [PAGE_BITS-1:0] page_mem  [FRAMES];
  logic [31:0]          stamp_mem [FRAMES];

  lru_cfg #(
    .FRAMES (FRAMES),
    .CNT_W  (CNT_W)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .frames_n (frames_n)
  );

  assign page_ext = 32'(in_data.page_number);
  assign page_in  = page_ext[PAGE_BITS-1:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_done) state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    accept   = 1'b0;
    rd_en    = 1'b0;
    do_write = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      ST_SCAN:  rd_en = (issue_r < n_r);
      ST_WRITE: do_write = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  assign scan_done = cmp_vld_r && (CNT_W'(cmp_idx_r) == (n_r - CNT_W'(1)));

  // shared compare unit: page match and oldest stamp, one entry per cycle
  assign hit_now = valid_r[cmp_idx_r] && (page_q == page_r);
  assign older   = (cmp_idx_r == '0) || (stamp_q < best_stamp_r);

  // write-back decision
  always_comb begin
    miss      = !hit_r;
    load      = 1'b0;
    slot      = hit_idx_r;
    outcome   = OUTCOME_HIT;
    evict_ext = '0;
    if (!hit_r) begin
      if (fill_r < n_r) begin
        load    = 1'b1;
        slot    = fill_r[IDX_W-1:0];
        outcome = OUTCOME_LOAD;
      end else begin
        slot      = best_idx_r;
        outcome   = OUTCOME_REPLACE;
        evict_ext = 32'(best_page_r);
      end
    end
    fault_nxt = (miss && (fault_r != '1)) ? fault_r + 32'd1 : fault_r;
    slot_ext  = 32'(slot);
  end

  // frame memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      page_q  <= page_mem[issue_r[IDX_W-1:0]];
      stamp_q <= stamp_mem[issue_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      if (miss) begin
        page_mem[slot] <= page_r;
      end
      stamp_mem[slot] <= clock_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      issue_r      <= '0;
      valid_r      <= '0;
      fill_r       <= '0;
      clock_r      <= '0;
      fault_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cmp_vld_r    <= rd_en;
      out_strobe_r <= do_write;
      if (accept) begin
        issue_r <= '0;
      end else if (rd_en) begin
        issue_r <= issue_r + CNT_W'(1);
      end
      if (accept) begin
        hit_r <= 1'b0;
      end else if (cmp_vld_r && hit_now) begin
        hit_r <= 1'b1;
      end
      if (do_write) begin
        if (last_r) begin
          // end of run
          valid_r <= '0;
          fill_r  <= '0;
          clock_r <= '0;
          fault_r <= '0;
        end else begin
          if (miss) begin
            valid_r[slot] <= 1'b1;
          end
          if (load) begin
            fill_r <= fill_r + CNT_W'(1);
          end
          clock_r <= clock_r + 32'd1;
          fault_r <= fault_nxt;
        end
      end
    end
  end

  // request and scan payload
  always_ff @(posedge clk) begin
    cmp_idx_r <= issue_r[IDX_W-1:0];
    if (accept) begin
      page_r <= page_in;
      last_r <= in_data.last_request;
      n_r    <= frames_n;
    end
    if (cmp_vld_r) begin
      if (!hit_r && hit_now) begin
        hit_idx_r <= cmp_idx_r;
      end
      if (older) begin
        best_stamp_r <= stamp_q;
        best_idx_r   <= cmp_idx_r;
        best_page_r  <= page_q;
      end
    end
    if (do_write) begin
      out_data_r.outcome      <= outcome;
      out_data_r.frame_index  <= slot_ext[2:0];
      out_data_r.evicted_page <= evict_ext[15:0];
      out_data_r.fault_total  <= fault_nxt;
      out_data_r.run_end      <= last_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_strobe_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == ST_WRITE))
    else $error("result strobe without a write-back");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= FRAMES)
    else $error("fill count beyond frame array");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && cmp_vld_r) |-> (CNT_W'(cmp_idx_r) < n_r))
    else $error("compare beyond active frames");

  a_hit_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE && hit_r) |-> valid_r[hit_idx_r])
    else $error("hit on an empty frame");

  a_busy_until_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy && !out_strobe_r))
    else $error("request accepted without entering the scan");

endmodule

/* bench/lru_page_replacement_top_test.sv */
`timescale 1ns / 100ps

module lru_page_replacement_top_test;
  import lru_pkg::*;

  localparam int NUM_FRAMES = 8;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int NUM_PHASES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] ADDR_FRAMES_IN_USE = {REG_FRAMES_IN_USE, 2'b00};

  typedef enum logic {
    ROW_REQUEST,
    ROW_CONFIG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] value;
    logic        last;
    logic        typed;
    rsp_t        want;
  } script_row_t;

  // hand-checked rows carry their result, the rest go through the predictor
  localparam int SCRIPT_LEN = 25;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{ROW_REQUEST, 16'h0000, 1'b0, 1'b1, '{OUTCOME_LOAD, 3'd0, 16'h0000, 32'd1, 1'b0}},
    '{ROW_REQUEST, 16'h0000, 1'b0, 1'b1, '{OUTCOME_HIT, 3'd0, 16'h0000, 32'd1, 1'b0}},
    '{ROW_REQUEST, 16'hffff, 1'b0, 1'b1, '{OUTCOME_LOAD, 3'd1, 16'h0000, 32'd2, 1'b0}},
    '{ROW_REQUEST, 16'h0001, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'h0002, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'h0003, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'h0004, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'h0005, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'h0006, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'h0007, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'hffff, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'h0008, 1'b1, 1'b0, '0},
    '{ROW_REQUEST, 16'h0000, 1'b0, 1'b1, '{OUTCOME_LOAD, 3'd0, 16'h0000, 32'd1, 1'b0}},
    '{ROW_CONFIG, 16'd0, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'h0005, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'h0005, 1'b0, 1'b0, '0},
    '{ROW_CONFIG, 16'd15, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'h8000, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'h0005, 1'b0, 1'b0, '0},
    '{ROW_CONFIG, 16'd3, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'h1234, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'h4321, 1'b0, 1'b0, '0},
    '{ROW_CONFIG, 16'd8, 1'b0, 1'b0, '0},
    '{ROW_REQUEST, 16'h8000, 1'b1, 1'b0, '0}
  };

  // no phase clears the run on purpose, so a new setting can land mid-run
  localparam logic [3:0] PHASE_FRAMES [NUM_PHASES] = '{
    4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd3, 4'd8
  };
  localparam int PHASE_IDLE [NUM_PHASES] = '{0, 77, 0, 37, 77, 0, 37, 77};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        in_data = '0;
  logic        out_strobe;
  rsp_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lru_page_replacement_top #(
    .FRAMES(NUM_FRAMES),
    .PAGE_BITS(16)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_strobe(out_strobe),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // frame table as the block should hold it
  logic [15:0] held_page [NUM_FRAMES] = '{default: '0};
  logic        held_valid [NUM_FRAMES] = '{default: 1'b0};
  logic [31:0] held_stamp [NUM_FRAMES] = '{default: '0};
  int          filled = 0;
  logic [31:0] request_tick = '0;
  logic [31:0] fault_tally = '0;
  logic [3:0]  frames_setting = FRAMES_IN_USE_RESET;

  rsp_t        pending_lookups [$];
  rsp_t        want_rsp;
  int          error_count = 0;
  int          cycle_count = 0;
  int          sender_idle_pct = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic rsp_t predict_lookup(req_t r);
    rsp_t res;
    int   n;
    int   slot;
    int   j;
    bit   hit;
    n = frames_setting;
    if (n < 1) n = 1;
    if (n > NUM_FRAMES) n = NUM_FRAMES;
    hit = 1'b0;
    slot = 0;
    for (j = 0; j < n; j++) begin
      if (!hit && held_valid[j] && held_page[j] == r.page_number) begin
        hit = 1'b1;
        slot = j;
      end
    end
    res = '0;
    res.outcome = OUTCOME_HIT;
    if (!hit) begin
      if (filled < n) begin
        slot = filled;
        filled++;
        res.outcome = OUTCOME_LOAD;
      end else begin
        // oldest stamp goes, lowest index on ties
        slot = 0;
        for (j = 1; j < n; j++) begin
          if (held_stamp[j] < held_stamp[slot]) slot = j;
        end
        res.evicted_page = held_page[slot];
        res.outcome = OUTCOME_REPLACE;
      end
      held_page[slot] = r.page_number;
      held_valid[slot] = 1'b1;
      if (fault_tally != '1) fault_tally++;
    end
    held_stamp[slot] = request_tick;
    request_tick++;
    res.frame_index = 3'(slot);
    res.fault_total = fault_tally;
    res.run_end = r.last_request;
    if (r.last_request) begin
      for (j = 0; j < NUM_FRAMES; j++) begin
        held_page[j] = '0;
        held_valid[j] = 1'b0;
        held_stamp[j] = '0;
      end
      filled = 0;
      request_tick = '0;
      fault_tally = '0;
    end
    return res;
  endfunction

  task automatic send_request(input req_t r, input bit typed, input rsp_t typed_want);
    rsp_t predicted;
    int   gap;
    start <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (busy);
    predicted = predict_lookup(r);
    pending_lookups.push_back(typed ? typed_want : predicted);
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    if (start) start <= 1'b0;
    while (pending_lookups.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_frames(input logic [3:0] value);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_FRAMES_IN_USE;
    // upper bits are junk the register should drop
    pwdata <= {28'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    frames_setting = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_lookups.size() == 0) begin
        $error("result with no request outstanding: %p", out_data);
        error_count++;
      end else begin
        want_rsp = pending_lookups.pop_front();
        if (out_data.outcome !== want_rsp.outcome) begin
          $error("outcome: expected %0d, got %0d", want_rsp.outcome, out_data.outcome);
          error_count++;
        end
        if (out_data.frame_index !== want_rsp.frame_index) begin
          $error("frame_index: expected %0d, got %0d",
                 want_rsp.frame_index, out_data.frame_index);
          error_count++;
        end
        if (out_data.evicted_page !== want_rsp.evicted_page) begin
          $error("evicted_page: expected %h, got %h",
                 want_rsp.evicted_page, out_data.evicted_page);
          error_count++;
        end
        if (out_data.fault_total !== want_rsp.fault_total) begin
          $error("fault_total: expected %0d, got %0d",
                 want_rsp.fault_total, out_data.fault_total);
          error_count++;
        end
        if (out_data.run_end !== want_rsp.run_end) begin
          $error("run_end: expected %0d, got %0d", want_rsp.run_end, out_data.run_end);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lru_page_replacement_top_test NOT OK");
      $finish;
    end
  end

  initial begin
    req_t        r;
    logic [15:0] page_pool [16];
    int          pool_size;
    int          k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_CONFIG) begin
        write_frames(SCRIPT[i].value[3:0]);
      end else begin
        r.page_number = SCRIPT[i].value;
        r.last_request = SCRIPT[i].last;
        send_request(r, SCRIPT[i].typed, SCRIPT[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_frames(PHASE_FRAMES[ph]);
      sender_idle_pct = PHASE_IDLE[ph];
      // small working set so hits and replacements both show up
      pool_size = $urandom_range(12, 2);
      for (k = 0; k < 16; k++) begin
        case ($urandom_range(9))
          0: page_pool[k] = 16'h0000;
          1: page_pool[k] = 16'hffff;
          default: page_pool[k] = 16'($urandom);
        endcase
      end
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == ITEMS_PER_PHASE / 2) wait_drained();
        if ($urandom_range(99) < 80) r.page_number = page_pool[$urandom_range(pool_size - 1)];
        else r.page_number = 16'($urandom);
        r.last_request = ($urandom_range(39) == 0);
        send_request(r, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (24) @(posedge clk);
    if (error_count == 0) begin
      $display("lru_page_replacement_top_test OK");
    end else begin
      $display("lru_page_replacement_top_test NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lru_pkg.sv
rtl/lru_cfg.sv
rtl/lru_page_replacement_top.sv
bench/lru_page_replacement_top_test.sv
